@@ rtl/mmfn_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Min-max feature normalizer package
// Shared widths, action and status codes, and interface types.
// ----------------------------------------------------------------------------
package mmfn_pkg;

   localparam int FEATURES  = 64;
   localparam int FEATURE_W = 6;
   localparam int VALUE_W   = 16;
   localparam int NORM_W    = 17;
   localparam int STATUS_W  = 3;
   localparam int ACTION_W  = 2;

   localparam int IDX_W   = (FEATURES > 1) ? $clog2(FEATURES) : 1;
   localparam int FEAT_XW = (IDX_W > FEATURE_W) ? IDX_W : FEATURE_W;

   localparam int DIV_STEPS = NORM_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [ACTION_W-1:0] ACT_OBSERVE   = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_NORMALIZE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR     = 2'd2;

   localparam logic [STATUS_W-1:0] STAT_OK     = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_LOW    = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_HIGH   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_FLAT   = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_UNSEEN = 3'd4;

   localparam logic [NORM_W-1:0] Q_ONE = 17'h10000;

   typedef struct packed {
      logic                      en;
      logic [IDX_W-1:0]          idx;
      logic signed [VALUE_W-1:0] low;
      logic signed [VALUE_W-1:0] high;
   } range_wr_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage : mmfn_pkg
`default_nettype wire

@@ rtl/mmfn_range_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Range store
// Per-feature minimum and maximum memory with registered read, plus
// per-feature observed flags that reset and clear at once.
// ----------------------------------------------------------------------------
module mmfn_range_store (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [mmfn_pkg::IDX_W-1:0]         rd_idx,
   output logic signed [mmfn_pkg::VALUE_W-1:0]     rd_low,
   output logic signed [mmfn_pkg::VALUE_W-1:0]     rd_high,
   input  wire logic [mmfn_pkg::IDX_W-1:0]         seen_idx,
   output logic                                    seen,
   input  wire mmfn_pkg::range_wr_type             wr,
   input  wire logic                               clear_all
);
   import mmfn_pkg::*;

   logic signed [VALUE_W-1:0] low_mem  [FEATURES];
   logic signed [VALUE_W-1:0] high_mem [FEATURES];
   logic [FEATURES-1:0]       seen_ff;
   logic [FEATURES-1:0]       seen_in;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         low_mem[wr.idx]  <= wr.low;
         high_mem[wr.idx] <= wr.high;
      end
      rd_low  <= low_mem[rd_idx];
      rd_high <= high_mem[rd_idx];
   end

   always_comb begin
      seen_in = seen_ff;
      if (clear_all) begin
         seen_in = '0;
      end else if (wr.en) begin
         seen_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   assign seen = seen_ff[seen_idx];

endmodule : mmfn_range_store
`default_nettype wire

@@ rtl/mmfn_divider.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Bit-serial divider
// Restoring division of num * 65536 by den, one quotient bit per cycle,
// for num not above den.
// ----------------------------------------------------------------------------
module mmfn_divider (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [mmfn_pkg::VALUE_W-1:0]   num,
   input  wire logic [mmfn_pkg::VALUE_W-1:0]   den,
   output mmfn_pkg::div_status_type            status,
   output logic [mmfn_pkg::NORM_W-1:0]         quotient
);
   import mmfn_pkg::*;

   logic [NORM_W-1:0]    rem_ff, rem_in;
   logic [NORM_W-1:0]    quo_ff, quo_in;
   logic [VALUE_W-1:0]   den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [NORM_W-1:0]    trial;
   logic                 fits;

   always_comb begin
      trial = (cnt_ff == '0) ? rem_ff : {rem_ff[NORM_W-2:0], 1'b0};
      fits  = trial >= {1'b0, den_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, num};
         quo_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? (trial - {1'b0, den_ff}) : trial;
         quo_in = {quo_ff[NORM_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

`ifndef ASSERT_OFF
   a_done_after_busy : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a preceding busy cycle");
   a_busy_done_excl : assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy and done together");
   a_rem_below_den : assert property (@(posedge clock) disable iff (reset)
      (busy_ff && cnt_ff != '0) |-> (rem_ff < {1'b0, den_ff}))
      else $error("divider remainder not below divisor");
   a_quo_range : assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (quo_ff <= Q_ONE))
      else $error("divider quotient above one");
`endif

endmodule : mmfn_divider
`default_nettype wire

@@ rtl/min_max_feature_normalizer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Min-max feature normalizer
// Per-feature minimum/maximum tracking and Q1.16 scaling of samples.
// ----------------------------------------------------------------------------
// Items are handled one at a time. Clear and unused actions end on accept;
// observe steps through accept, range read and update. Normalize of a
// sample in a non-flat range steps through accept, range read, evaluate,
// the bit-serial divider (one of the 17 quotient bits per cycle) and emit;
// the special cases (never observed, flat, below, above) skip the divider.
// Results land in an output register, so the next item is accepted while
// a result waits. Only normalize returns a result. Range memories start
// undefined; observed flags reset to zero and clear drops them all at once.
module min_max_feature_normalizer (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // feature[5:0], value[21:6], zero[23:22]
   input  wire logic [1:0]  req_tuser,   // action[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // feature_out[5:0], normalized[22:6], zero[23]
   output logic [2:0]       rsp_tuser    // status[2:0]
);
   import mmfn_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_EVAL = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;

   logic [2:0]                state_ff, state_in;
   logic [ACTION_W-1:0]       act_ff, act_in;
   logic [FEATURE_W-1:0]      feat_ff, feat_in;
   logic signed [VALUE_W-1:0] value_ff, value_in;
   logic [NORM_W-1:0]         res_norm_ff, res_norm_in;
   logic [STATUS_W-1:0]       res_stat_ff, res_stat_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [FEATURE_W-1:0]      rsp_feat_ff, rsp_feat_in;
   logic [NORM_W-1:0]         rsp_norm_ff, rsp_norm_in;
   logic [STATUS_W-1:0]       rsp_stat_ff, rsp_stat_in;

   logic                      req_xfer;
   logic [FEAT_XW-1:0]        feat_ext;
   logic [IDX_W-1:0]          idx;
   logic                      feat_ok;
   logic signed [VALUE_W-1:0] lo;
   logic signed [VALUE_W-1:0] hi;
   logic                      seen_bit;
   logic                      seen;
   logic signed [VALUE_W:0]   num_s;
   logic signed [VALUE_W:0]   den_s;
   range_wr_type              wr;
   logic                      clear_all;
   logic                      div_start;
   div_status_type            div_st;
   logic [NORM_W-1:0]         div_quo;
   logic                      out_free;

   mmfn_range_store u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (idx),
      .rd_low    (lo),
      .rd_high   (hi),
      .seen_idx  (idx),
      .seen      (seen_bit),
      .wr        (wr),
      .clear_all (clear_all)
   );

   mmfn_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num_s[VALUE_W-1:0]),
      .den      (den_s[VALUE_W-1:0]),
      .status   (div_st),
      .quotient (div_quo)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign feat_ext   = FEAT_XW'(feat_ff);
   assign idx        = feat_ext[IDX_W-1:0];
   assign feat_ok    = {1'b0, feat_ext} < (FEAT_XW + 1)'(FEATURES);
   assign seen       = feat_ok && seen_bit;
   assign num_s      = {value_ff[VALUE_W-1], value_ff} - {lo[VALUE_W-1], lo};
   assign den_s      = {hi[VALUE_W-1], hi} - {lo[VALUE_W-1], lo};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      feat_in     = feat_ff;
      value_in    = value_ff;
      res_norm_in = res_norm_ff;
      res_stat_in = res_stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_feat_in  = rsp_feat_ff;
      rsp_norm_in  = rsp_norm_ff;
      rsp_stat_in  = rsp_stat_ff;
      wr.en       = 1'b0;
      wr.idx      = idx;
      wr.low      = value_ff;
      wr.high     = value_ff;
      clear_all   = 1'b0;
      div_start   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               act_in   = req_tuser;
               feat_in  = req_tdata[5:0];
               value_in = req_tdata[21:6];
               case (req_tuser)
                  ACT_OBSERVE, ACT_NORMALIZE: state_in = S_READ;
                  ACT_CLEAR: clear_all = 1'b1;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (act_ff == ACT_OBSERVE) begin
               state_in = S_IDLE;
               wr.en    = feat_ok;
               if (seen) begin
                  wr.low  = (value_ff < lo) ? value_ff : lo;
                  wr.high = (value_ff > hi) ? value_ff : hi;
               end
            end else begin
               state_in    = S_EMIT;
               res_norm_in = '0;
               if (!seen) begin
                  res_stat_in = STAT_UNSEEN;
               end else if (hi <= lo) begin
                  res_stat_in = STAT_FLAT;
               end else if (value_ff < lo) begin
                  res_stat_in = STAT_LOW;
               end else if (value_ff > hi) begin
                  res_stat_in = STAT_HIGH;
                  res_norm_in = Q_ONE;
               end else begin
                  res_stat_in = STAT_OK;
                  div_start   = 1'b1;
                  state_in    = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_st.done) begin
               res_norm_in = div_quo;
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_feat_in  = feat_ff;
               rsp_norm_in  = res_norm_ff;
               rsp_stat_in  = res_stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      feat_ff     <= feat_in;
      value_ff    <= value_in;
      res_norm_ff <= res_norm_in;
      res_stat_ff <= res_stat_in;
      rsp_feat_ff <= rsp_feat_in;
      rsp_norm_ff <= rsp_norm_in;
      rsp_stat_ff <= rsp_stat_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_norm_ff, rsp_feat_ff};
   assign rsp_tuser  = rsp_stat_ff;

endmodule : min_max_feature_normalizer
`default_nettype wire
